>>> rtl/core/lir_pkg.sv
// lir_pkg: shared types and constants for the linear interpolation resampler
// no dependencies; used by the interfaces, controller, datapath and top level

package lir_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int MAX_CHANNELS = 8;
  localparam int POS_FRAC     = 24;
  localparam int WALK_W       = 33;

  localparam logic [WALK_W-1:0] POS_ONE = WALK_W'(1) << POS_FRAC;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [1:0] {
    REG_PHASE_STEP  = 2'd0,
    REG_OUT_COUNT   = 2'd1,
    REG_CHAN_COUNT  = 2'd2
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic                load;
    logic                issue;
    logic                last;
    logic                done;
    logic [POS_FRAC-1:0] frac;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic prod_valid;
    logic advance;
  } stat_t;

endpackage

>>> rtl/core/lir_if.sv
// lir_in_if / lir_out_if: valid/ready channels for input and result frames
// depends on lir_pkg

interface lir_in_if;
  logic                 valid;
  logic                 ready;
  lir_pkg::sample_t     sample_ch0;
  lir_pkg::sample_t     sample_ch1;
  lir_pkg::sample_t     sample_ch2;
  lir_pkg::sample_t     sample_ch3;
  lir_pkg::sample_t     sample_ch4;
  lir_pkg::sample_t     sample_ch5;
  lir_pkg::sample_t     sample_ch6;
  lir_pkg::sample_t     sample_ch7;
  logic                 zero_frame;
  logic                 restart;

  modport source (
    output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
           sample_ch4, sample_ch5, sample_ch6, sample_ch7, zero_frame, restart,
    input  ready
  );
  modport sink (
    input  valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
           sample_ch4, sample_ch5, sample_ch6, sample_ch7, zero_frame, restart,
    output ready
  );
endinterface

interface lir_out_if;
  logic                 valid;
  logic                 ready;
  lir_pkg::sample_t     result_ch0;
  lir_pkg::sample_t     result_ch1;
  lir_pkg::sample_t     result_ch2;
  lir_pkg::sample_t     result_ch3;
  lir_pkg::sample_t     result_ch4;
  lir_pkg::sample_t     result_ch5;
  lir_pkg::sample_t     result_ch6;
  lir_pkg::sample_t     result_ch7;
  logic                 last_of_run;
  logic                 stream_done;

  modport source (
    output valid, result_ch0, result_ch1, result_ch2, result_ch3,
           result_ch4, result_ch5, result_ch6, result_ch7, last_of_run, stream_done,
    input  ready
  );
  modport sink (
    input  valid, result_ch0, result_ch1, result_ch2, result_ch3,
           result_ch4, result_ch5, result_ch6, result_ch7, last_of_run, stream_done,
    output ready
  );
endinterface

>>> rtl/core/lir_ctrl.sv
// lir_ctrl: frame sequencer; walks output positions across one input interval
// depends on lir_pkg

module lir_ctrl #(
  parameter int MAX_RUN = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_restart,
  output logic                 in_ready,
  input  logic [31:0]          phase_step,
  input  logic [23:0]          out_frame_count,
  input  lir_pkg::stat_t       st,
  output lir_pkg::cmd_t        cmd
);

  localparam int RUN_W = $clog2(MAX_RUN + 1);
  localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(MAX_RUN);

  lir_pkg::state_t                 state_r, state_nxt;
  logic [31:0]                     pos_r, pos_nxt;
  logic [23:0]                     emitted_r, emitted_nxt;
  logic                            have_prev_r, have_prev_nxt;
  logic [lir_pkg::WALK_W-1:0]      walk_r, walk_nxt;
  logic [RUN_W-1:0]                run_cnt_r, run_cnt_nxt;

  logic                            load;
  logic                            issue_ok;
  logic                            more;
  logic                            next_more;
  logic [lir_pkg::WALK_W-1:0]      walk_add;
  logic [lir_pkg::WALK_W-1:0]      walk_end;
  logic [23:0]                     emit_inc;
  logic [RUN_W-1:0]                run_inc;
  logic                            finish;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lir_pkg::ST_IDLE;
      pos_r       <= '0;
      emitted_r   <= '0;
      have_prev_r <= 1'b0;
      walk_r      <= '0;
      run_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      emitted_r   <= emitted_nxt;
      have_prev_r <= have_prev_nxt;
      walk_r      <= walk_nxt;
      run_cnt_r   <= run_cnt_nxt;
    end
  end

  always_comb begin
    in_ready  = (state_r == lir_pkg::ST_IDLE) && !st.prod_valid;
    load      = in_valid && in_ready;
    issue_ok  = !st.prod_valid || st.advance;
    walk_add  = walk_r + {1'b0, phase_step};
    emit_inc  = emitted_r + 24'd1;
    run_inc   = run_cnt_r + RUN_W'(1);
    more      = (emitted_r < out_frame_count) && (walk_r < lir_pkg::POS_ONE) &&
                (run_cnt_r < RUN_MAX);
    next_more = (emit_inc < out_frame_count) && (walk_add < lir_pkg::POS_ONE) &&
                (run_inc < RUN_MAX);

    state_nxt     = state_r;
    pos_nxt       = pos_r;
    emitted_nxt   = emitted_r;
    have_prev_nxt = have_prev_r;
    walk_nxt      = walk_r;
    run_cnt_nxt   = run_cnt_r;
    finish        = 1'b0;
    walk_end      = walk_r;

    cmd       = '0;
    cmd.load  = load;
    cmd.frac  = walk_r[lir_pkg::POS_FRAC-1:0];

    case (state_r)
      lir_pkg::ST_IDLE: begin
        if (load) begin
          have_prev_nxt = 1'b1;
          if (in_restart) begin
            pos_nxt     = '0;
            emitted_nxt = '0;
          end else if (have_prev_r) begin
            state_nxt   = lir_pkg::ST_RUN;
            walk_nxt    = {1'b0, pos_r};
            run_cnt_nxt = '0;
          end
        end
      end
      lir_pkg::ST_RUN: begin
        if (more) begin
          if (issue_ok) begin
            cmd.issue   = 1'b1;
            cmd.last    = !next_more;
            cmd.done    = (emit_inc == out_frame_count);
            emitted_nxt = emit_inc;
            walk_nxt    = walk_add;
            run_cnt_nxt = run_inc;
            if (!next_more) begin
              finish   = 1'b1;
              walk_end = walk_add;
            end
          end
        end else begin
          finish = 1'b1;
        end
        if (finish) begin
          state_nxt = lir_pkg::ST_IDLE;
          pos_nxt   = (walk_end >= lir_pkg::POS_ONE) ?
                      32'(walk_end - lir_pkg::POS_ONE) : 32'd0;
        end
      end
      default: begin
        state_nxt = lir_pkg::ST_IDLE;
      end
    endcase
  end

  a_issue_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (!st.prod_valid || st.advance))
    else $error("word issued into a full product stage");

  a_run_cap: assert property (@(posedge clk) disable iff (!rst_n)
    run_cnt_r <= RUN_MAX)
    else $error("run counter beyond cap");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue && cmd.last) |=> (state_r == lir_pkg::ST_IDLE))
    else $error("run continued after last word");

  a_idle_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lir_pkg::ST_IDLE && !load) |=> $stable(emitted_r))
    else $error("output count moved while idle");

endmodule

>>> rtl/core/lir_dpath.sv
// lir_dpath: frame registers, per-lane multiply stage and rounding/saturating output register
// depends on lir_pkg and lir_out_if

module lir_dpath #(
  parameter int FRAC_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lir_pkg::cmd_t        cmd,
  output lir_pkg::stat_t       st,
  input  lir_pkg::sample_t     in_samples [lir_pkg::MAX_CHANNELS],
  input  logic                 in_zero,
  input  logic [3:0]           channel_count,
  lir_out_if.source            out_word
);

  localparam int SB  = lir_pkg::SAMPLE_BITS;
  localparam int NCH = lir_pkg::MAX_CHANNELS;
  localparam int PW  = SB + FRAC_BITS + 2;
  localparam int QW  = PW - FRAC_BITS;
  localparam int SW  = SB + 3;
  localparam logic signed [PW-1:0] RND = PW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (SB - 1)) - 1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  lir_pkg::sample_t          prev_r [NCH];
  lir_pkg::sample_t          cur_r  [NCH];
  logic signed [PW-1:0]      prod_r [NCH];
  logic                      prod_valid_r;
  logic                      tag_last_r;
  logic                      tag_done_r;
  lir_pkg::sample_t          res_r  [NCH];
  logic                      out_valid_r;
  logic                      last_r;
  logic                      done_r;

  logic signed [SB:0]        diff    [NCH];
  logic signed [PW-1:0]      prod_nxt [NCH];
  logic signed [PW-1:0]      biased  [NCH];
  logic signed [QW-1:0]      rnd_q   [NCH];
  logic signed [SW-1:0]      sum     [NCH];
  lir_pkg::sample_t          res_nxt [NCH];
  logic signed [FRAC_BITS:0] mu_s;
  logic                      advance;

  assign advance       = !out_valid_r || out_word.ready;
  assign st.prod_valid = prod_valid_r;
  assign st.advance    = advance;
  assign mu_s = signed'({1'b0, cmd.frac[lir_pkg::POS_FRAC-1 -: FRAC_BITS]});

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      diff[c]     = (SB+1)'(cur_r[c]) - (SB+1)'(prev_r[c]);
      prod_nxt[c] = PW'(diff[c]) * PW'(mu_s);
      biased[c]   = prod_r[c] + RND;
      rnd_q[c]    = signed'(biased[c][PW-1:FRAC_BITS]);
      sum[c]      = SW'(prev_r[c]) + SW'(rnd_q[c]);
      if (4'(c) >= channel_count) begin
        res_nxt[c] = '0;
      end else if (sum[c] > SAT_HI) begin
        res_nxt[c] = SAT_HI[SB-1:0];
      end else if (sum[c] < SAT_LO) begin
        res_nxt[c] = SAT_LO[SB-1:0];
      end else begin
        res_nxt[c] = sum[c][SB-1:0];
      end
    end
  end

  // frame registers, product stage and output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int c = 0; c < NCH; c++) begin
        prev_r[c] <= cur_r[c];
        cur_r[c]  <= in_zero ? '0 : in_samples[c];
      end
    end
    if (cmd.issue) begin
      for (int c = 0; c < NCH; c++) begin
        prod_r[c] <= prod_nxt[c];
      end
      tag_last_r <= cmd.last;
      tag_done_r <= cmd.done;
    end
    if (advance && prod_valid_r) begin
      for (int c = 0; c < NCH; c++) begin
        res_r[c] <= res_nxt[c];
      end
      last_r <= tag_last_r;
      done_r <= tag_done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.issue) begin
        prod_valid_r <= 1'b1;
      end else if (advance) begin
        prod_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= prod_valid_r;
      end
    end
  end

  assign out_word.valid       = out_valid_r;
  assign out_word.result_ch0  = res_r[0];
  assign out_word.result_ch1  = res_r[1];
  assign out_word.result_ch2  = res_r[2];
  assign out_word.result_ch3  = res_r[3];
  assign out_word.result_ch4  = res_r[4];
  assign out_word.result_ch5  = res_r[5];
  assign out_word.result_ch6  = res_r[6];
  assign out_word.result_ch7  = res_r[7];
  assign out_word.last_of_run = last_r;
  assign out_word.stream_done = done_r;

endmodule

>>> rtl/core/linear_interp_resampler_top.sv
// linear_interp_resampler_top: multichannel linear interpolation resampler
// depends on lir_pkg, lir_if, lir_ctrl and lir_dpath
//
//   channel    dir  handshake        carries
//   in_word    in   valid/ready      sample_ch0..7, zero_frame, restart
//   out_word   out  valid/ready      result_ch0..7, last_of_run, stream_done
//   cfg_*      in   cfg_wr_en only   cfg_index selects register, cfg_wdata value
//
// a frame is taken on an in_word handshake; each output it causes is issued
// into the 8-lane multiply stage and then lands in the output register,
// with n outputs per frame (n at most MAX_RUN)
// the next frame is taken once the run is issued and the multiply stage is empty;
// the output register may still hold an untaken word at that point
// out_word.ready low with a word held stalls the multiply stage and the sequencer, nothing is lost
// synchronous active-low reset clears control state and loads register defaults

module linear_interp_resampler_top #(
  parameter int FRAC_BITS = 24,
  parameter int MAX_RUN   = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  lir_in_if.sink       in_word,
  lir_out_if.source    out_word,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  // configuration registers
  logic [31:0]        phase_step_r;
  logic [23:0]        out_frame_count_r;
  logic [3:0]         channel_count_r;

  lir_pkg::cmd_t      cmd;
  lir_pkg::stat_t     st;
  lir_pkg::sample_t   in_samples [lir_pkg::MAX_CHANNELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r      <= 32'h0100_0000;   // 1.0 in Q8.24
      out_frame_count_r <= 24'd1024;
      channel_count_r   <= 4'd2;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lir_pkg::REG_PHASE_STEP: phase_step_r      <= cfg_wdata;
        lir_pkg::REG_OUT_COUNT:  out_frame_count_r <= cfg_wdata[23:0];
        lir_pkg::REG_CHAN_COUNT: channel_count_r   <= cfg_wdata[3:0];
        default: ;                            // unmapped index, write dropped
      endcase
    end
  end

  // gather the lanes of the input word
  assign in_samples[0] = in_word.sample_ch0;
  assign in_samples[1] = in_word.sample_ch1;
  assign in_samples[2] = in_word.sample_ch2;
  assign in_samples[3] = in_word.sample_ch3;
  assign in_samples[4] = in_word.sample_ch4;
  assign in_samples[5] = in_word.sample_ch5;
  assign in_samples[6] = in_word.sample_ch6;
  assign in_samples[7] = in_word.sample_ch7;

  // sequencer: restart handling, position walk, run cap and output count
  lir_ctrl #(
    .MAX_RUN (MAX_RUN)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_word.valid),
    .in_restart      (in_word.restart),
    .in_ready        (in_word.ready),
    .phase_step      (phase_step_r),
    .out_frame_count (out_frame_count_r),
    .st              (st),
    .cmd             (cmd)
  );

  // lanes: previous/current frame, multiply, round, saturate, output register
  lir_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_samples    (in_samples),
    .in_zero       (in_word.zero_frame),
    .channel_count (channel_count_r),
    .out_word      (out_word)
  );

endmodule
